@@ hw/rtl/tone_queue_and_music_sequencer_top_defines.svh @@
// Assertion helpers for the tone sequencer. Both expect clk and arst_n in scope.
`ifndef TONE_QUEUE_AND_MUSIC_SEQUENCER_TOP_DEFINES_SVH
`define TONE_QUEUE_AND_MUSIC_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define TQMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TQMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TQMS_ASSERT_NOW(lbl, ante, cons, msg)
`define TQMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/tqms_pkg.sv @@
`timescale 1ns / 1ps
package tqms_pkg;

	// field widths
	localparam int REQ_W  = 3;
	localparam int FREQ_W = 16;
	localparam int DUR_W  = 16;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;
	localparam int CNT_W  = 8;
	localparam int ENT_W  = FREQ_W + DUR_W;

	// storage
	localparam int QUEUE_DEPTH = 128;
	localparam int MUSIC_DEPTH = 64;
	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFW = $clog2(QUEUE_DEPTH + 1);
	localparam int MAW = (MUSIC_DEPTH > 1) ? $clog2(MUSIC_DEPTH) : 1;
	localparam int MLW = (MUSIC_DEPTH > 1) ? $clog2(MUSIC_DEPTH + 1) : 1;

	// timer input clock and the divider built around it
	localparam int PIT_W = 21;
	localparam logic [PIT_W-1:0] PIT_CLOCK = 21'd1193180;
	localparam int DIV_CW = $clog2(PIT_W);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MUTE  = 1'b0,
		CFG_PAUSE = 1'b1
	} cfg_reg_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_ENQUEUE = 3'd1,
		REQ_LOAD    = 3'd2,
		REQ_START   = 3'd3,
		REQ_CLEAR   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ_Q,
		ST_READ_M,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // capture input beat
		logic q_push;     // enqueue note
		logic drop;       // enqueue refused, queue full
		logic m_load;     // write music table slot
		logic m_start;    // start / stop music
		logic q_clear;    // empty the queue
		logic q_read;     // read queue head
		logic m_read;     // read current music entry
		logic q_adv;      // count down / retire queue head
		logic m_adv;      // music tick bookkeeping
		logic sel_music;  // tone comes from music entry
		logic gate_off;   // silence speaker
		logic div_start;  // launch divisor computation
		logic tone_set;   // take quotient, speaker on
		logic out_load;   // capture result beat
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t req;
		logic q_empty;
		logic q_full;
		logic music_on;
		logic tone_off;
		logic div_busy;
		logic div_done;
	} sts_t;

endpackage

@@ hw/rtl/tqms_if.sv @@
`timescale 1ns / 1ps
interface tqms_in_if import tqms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [FREQ_W-1:0] frequency;
	logic [DUR_W-1:0]  duration_ticks;
	logic [IDX_W-1:0]  music_index;
	logic [LEN_W-1:0]  music_length;

	modport source (
		output valid, req_type, frequency, duration_ticks, music_index, music_length,
		input  ready
	);
	modport sink (
		input  valid, req_type, frequency, duration_ticks, music_index, music_length,
		output ready
	);
endinterface

interface tqms_out_if import tqms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              speaker_on;
	logic [FREQ_W-1:0] pit_divisor;
	logic [CNT_W-1:0]  queue_count;
	logic              accepted;

	modport source (
		output valid, speaker_on, pit_divisor, queue_count, accepted,
		input  ready
	);
	modport sink (
		input  valid, speaker_on, pit_divisor, queue_count, accepted,
		output ready
	);
endinterface

@@ hw/rtl/tqms_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: PIT_CLOCK / divisor, one quotient bit per cycle.
module tqms_div import tqms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FREQ_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [FREQ_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] quo_q;
	logic [FREQ_W-1:0] dvs_q;
	logic [FREQ_W:0]   trial;
	logic              qbit;

	assign trial = {rem_q, PIT_CLOCK[cnt_q]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(PIT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// only the low 16 quotient bits are kept; older bits shift out the top
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? FREQ_W'(trial - {1'b0, dvs_q}) : trial[FREQ_W-1:0];
			quo_q <= {quo_q[FREQ_W-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/tqms_datapath.sv @@
`timescale 1ns / 1ps
module tqms_datapath import tqms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [FREQ_W-1:0]     frequency,
	input  logic [DUR_W-1:0]      duration_ticks,
	input  logic [IDX_W-1:0]      music_index,
	input  logic [LEN_W-1:0]      music_length,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  speaker_on,
	output logic [FREQ_W-1:0]     pit_divisor,
	output logic [CNT_W-1:0]      queue_count,
	output logic                  accepted
);

	// captured input beat
	req_t              req_q;
	logic [FREQ_W-1:0] freq_q;
	logic [DUR_W-1:0]  dur_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;

	// sequencer state
	logic              mute_q;
	logic              pause_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW-1:0]    wr_ptr_q;
	logic [QFW-1:0]    fill_q;
	logic [MLW-1:0]    mlen_q;
	logic [MAW-1:0]    mpos_q;
	logic [DUR_W-1:0]  mtick_q;
	logic              gate_q;
	logic [FREQ_W-1:0] tdiv_q;
	logic              acc_q;

	// memories
	logic [ENT_W-1:0] qmem [QUEUE_DEPTH];
	logic [ENT_W-1:0] mmem [MUSIC_DEPTH];
	logic [ENT_W-1:0] q_rdata;
	logic [ENT_W-1:0] m_rdata;

	logic              q_we;
	logic [QAW-1:0]    q_waddr;
	logic [ENT_W-1:0]  q_wdata;
	logic              q_left_zero;
	logic [FREQ_W-1:0] tone_freq;
	logic              div_busy;
	logic              div_done;
	logic [FREQ_W-1:0] div_quo;

	assign q_left_zero = (q_rdata[DUR_W-1:0] == '0);
	assign q_we        = cmd.q_push || (cmd.q_adv && !q_left_zero);
	assign q_waddr     = cmd.q_push ? wr_ptr_q : rd_ptr_q;
	assign q_wdata     = cmd.q_push ? {freq_q, dur_q}
	                                : {q_rdata[ENT_W-1:DUR_W], q_rdata[DUR_W-1:0] - 1'b1};
	assign tone_freq   = cmd.sel_music ? m_rdata[ENT_W-1:DUR_W] : q_rdata[ENT_W-1:DUR_W];

	always_ff @(posedge clk) begin
		if (q_we)
			qmem[q_waddr] <= q_wdata;
		if (cmd.q_read)
			q_rdata <= qmem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.m_load && (32'(idx_q) < 32'(MUSIC_DEPTH)))
			mmem[MAW'(idx_q)] <= {freq_q, dur_q};
		if (cmd.m_read)
			m_rdata <= mmem[mpos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q  <= req_t'(req_type);
			freq_q <= frequency;
			dur_q  <= duration_ticks;
			idx_q  <= music_index;
			len_q  <= music_length;
		end
		if (cmd.out_load) begin
			speaker_on  <= gate_q;
			pit_divisor <= tdiv_q;
			queue_count <= CNT_W'(fill_q);
			accepted    <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q   <= 1'b0;
			pause_q  <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			mlen_q   <= '0;
			mpos_q   <= '0;
			mtick_q  <= '0;
			gate_q   <= 1'b0;
			tdiv_q   <= '0;
			acc_q    <= 1'b1;
		end else begin
			if (cfg_we && cfg_index == CFG_MUTE)
				mute_q <= cfg_data[0];
			if (cfg_we && cfg_index == CFG_PAUSE)
				pause_q <= cfg_data[0];

			if (cmd.load_in)
				acc_q <= 1'b1;
			if (cmd.drop)
				acc_q <= 1'b0;

			if (cmd.q_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
				fill_q   <= fill_q + 1'b1;
			end
			if (cmd.q_adv && q_left_zero) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
				fill_q   <= fill_q - 1'b1;
			end
			if (cmd.q_clear) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				fill_q   <= '0;
			end

			if (cmd.m_start) begin
				mlen_q  <= (32'(len_q) > 32'(MUSIC_DEPTH)) ? MLW'(MUSIC_DEPTH) : MLW'(len_q);
				mpos_q  <= '0;
				mtick_q <= '0;
			end
			if (cmd.m_adv) begin
				if (m_rdata[DUR_W-1:0] == mtick_q) begin
					mtick_q <= '0;
					mpos_q  <= (32'(mpos_q) + 32'd1 == 32'(mlen_q)) ? '0 : mpos_q + 1'b1;
				end else begin
					mtick_q <= mtick_q + 1'b1;
				end
			end

			if (cmd.gate_off)
				gate_q <= 1'b0;
			if (cmd.tone_set) begin
				gate_q <= 1'b1;
				tdiv_q <= div_quo;
			end
		end
	end

	tqms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (tone_freq),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sts.req      = req_q;
		sts.q_empty  = (fill_q == '0);
		sts.q_full   = (32'(fill_q) >= QUEUE_DEPTH);
		sts.music_on = (mlen_q != '0) && !pause_q;
		sts.tone_off = mute_q || (tone_freq == '0);
		sts.div_busy = div_busy;
		sts.div_done = div_done;
	end

endmodule

@@ hw/rtl/tqms_ctrl.sv @@
`timescale 1ns / 1ps
module tqms_ctrl import tqms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_DONE;
				if (sts.req == REQ_TICK) begin
					if (!sts.q_empty)
						state_d = ST_READ_Q;
					else if (sts.music_on)
						state_d = ST_READ_M;
				end
			end
			ST_READ_Q, ST_READ_M: begin
				state_d = sts.tone_off ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DECODE: begin
				unique case (sts.req)
					REQ_TICK: begin
						if (!sts.q_empty)
							cmd.q_read = 1'b1;
						else if (sts.music_on)
							cmd.m_read = 1'b1;
						else
							cmd.gate_off = 1'b1;
					end
					REQ_ENQUEUE: begin
						if (sts.q_full)
							cmd.drop = 1'b1;
						else
							cmd.q_push = 1'b1;
					end
					REQ_LOAD:  cmd.m_load  = 1'b1;
					REQ_START: cmd.m_start = 1'b1;
					REQ_CLEAR: cmd.q_clear = 1'b1;
					default: ;
				endcase
			end
			ST_READ_Q: begin
				cmd.q_adv     = 1'b1;
				cmd.gate_off  = sts.tone_off;
				cmd.div_start = !sts.tone_off;
			end
			ST_READ_M: begin
				cmd.m_adv     = 1'b1;
				cmd.sel_music = 1'b1;
				cmd.gate_off  = sts.tone_off;
				cmd.div_start = !sts.tone_off;
			end
			ST_DIV: begin
				cmd.tone_set = sts.div_done;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/tone_queue_and_music_sequencer_top.sv @@
`timescale 1ns / 1ps
// Tone queue and music sequencer. Every input beat carries one request (tick,
// enqueue note, load music slot, start music, clear queue) and yields exactly
// one result beat with the speaker gate, the current timer divisor, the queue
// fill and whether an enqueue was taken. Requests are handled one at a time.
// A tick that plays a tone has its result loaded once the divider is done:
// the divisor 1193180 / frequency comes out of a restoring divider that
// produces one of its 21 quotient bits per cycle. Other requests, and
// ticks with nothing to read, go from decode straight to done; a tick that
// reads a silent or muted note or music entry passes a read state first.
// The next beat can be accepted in the cycle after the result is loaded.
// The result waits in an output register while the next request is taken.
// mute and pause are written through cfg port (index 0, 1); the user must do so while idle, unenforced by the block.
// The note queue (128 entries) and music table (64 entries) are plain RAMs
// with no reset; a music slot must be loaded before it is played.
`include "tone_queue_and_music_sequencer_top_defines.svh"

module tone_queue_and_music_sequencer_top import tqms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tqms_in_if.sink               in_ch,
	tqms_out_if.source            out_ch
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: one request in flight
	tqms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// queue, music table, tone state, divider and result register
	tqms_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (in_ch.req_type),
		.frequency      (in_ch.frequency),
		.duration_ticks (in_ch.duration_ticks),
		.music_index    (in_ch.music_index),
		.music_length   (in_ch.music_length),
		.cmd            (cmd),
		.sts            (sts),
		.speaker_on     (out_ch.speaker_on),
		.pit_divisor    (out_ch.pit_divisor),
		.queue_count    (out_ch.queue_count),
		.accepted       (out_ch.accepted)
	);

	// an accepted beat takes the controller out of idle
	`TQMS_ASSERT_NEXT(a_leave_idle, in_ch.valid && in_ch.ready, !in_ch.ready, "accept did not leave idle")
	// a refused enqueue is only reported with a full queue
	`TQMS_ASSERT_NOW(a_drop_full, out_ch.valid && !out_ch.accepted, out_ch.queue_count == CNT_W'(QUEUE_DEPTH), "drop with room left")
	// divider never runs while a new beat can be taken
	`TQMS_ASSERT_NOW(a_div_busy, sts.div_busy, !in_ch.ready, "divider busy while idle")

endmodule
